### hw/rtl/fbbc_pkg.sv
// Shared types, constants and bucket hash for the flow bucket byte counter.
`default_nettype none

package fbbc_pkg;

	localparam int unsigned COUNTER_WIDTH_DEF = 32;
	localparam int unsigned BUCKET_W          = 8;
	localparam int unsigned BUCKET_COUNT      = 256;
	localparam int unsigned ADDR_W            = 32;
	localparam int unsigned PORT_W            = 16;
	localparam int unsigned LEN_W             = 16;
	localparam int unsigned OVH_W             = 8;
	localparam int unsigned ADD_W             = 17;
	localparam int unsigned DIR_W             = 2;
	localparam int unsigned OUT_CNT_W         = 32;
	localparam int unsigned QUEUE_DEPTH       = 2;
	localparam int unsigned CFG_INDEX_W       = 1;
	localparam int unsigned CFG_DATA_W        = 32;
	localparam int unsigned S_TDATA_W         = 120;
	localparam int unsigned M_TDATA_W         = 72;

	localparam logic [ADDR_W-1:0] LOCAL_ADDRESS_RESET   = 32'h83CE1DCD;
	localparam logic [OVH_W-1:0]  LENGTH_OVERHEAD_RESET = 8'd24;

	typedef enum logic [0:0] {
		OP_COUNT = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_NONE = 2'd0,
		DIR_OUT  = 2'd1,
		DIR_IN   = 2'd2
	} dir_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_LOCAL_ADDRESS   = 1'b0,
		CFG_LENGTH_OVERHEAD = 1'b1
	} cfg_index_t;

	typedef struct packed {
		op_t                 op;
		dir_t                dir;
		logic [BUCKET_W-1:0] bucket;
		logic [ADD_W-1:0]    add;
	} work_t;

	function automatic logic [BUCKET_W-1:0] form_bucket(input logic [ADDR_W-1:0] addr,
			input logic [PORT_W-1:0] port);
		logic [BUCKET_W-1:0] b;
		b = {addr[31], addr[28], addr[24], addr[18], addr[13], port[15], port[10], port[4]};
		if (addr == '0) begin
			b = '0;
		end
		return b;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/fbbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fbbc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/fbbc_front.sv
// Front end: configuration registers, item intake and direction/bucket classification.
`default_nettype none

module fbbc_front import fbbc_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic                   s_tuser,  // op
	input  wire logic [S_TDATA_W-1:0]   s_tdata,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   q_full,
	input  wire logic                   clear_busy,
	output logic                        push,
	output work_t                       push_item
);

	logic [ADDR_W-1:0] local_address_q;
	logic [OVH_W-1:0]  length_overhead_q;

	logic [ADDR_W-1:0]   source_address;
	logic [ADDR_W-1:0]   dest_address;
	logic [PORT_W-1:0]   source_port;
	logic [PORT_W-1:0]   dest_port;
	logic [LEN_W-1:0]    wire_length;
	logic [BUCKET_W-1:0] read_bucket;
	op_t                 op;
	dir_t                dir;
	logic [BUCKET_W-1:0] bucket;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q   <= LOCAL_ADDRESS_RESET;
			length_overhead_q <= LENGTH_OVERHEAD_RESET;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_LOCAL_ADDRESS: begin
					local_address_q <= cfg_data[ADDR_W-1:0];
				end
				CFG_LENGTH_OVERHEAD: begin
					length_overhead_q <= cfg_data[OVH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign source_address = s_tdata[31:0];
	assign dest_address   = s_tdata[63:32];
	assign source_port    = s_tdata[79:64];
	assign dest_port      = s_tdata[95:80];
	assign wire_length    = s_tdata[111:96];
	assign read_bucket    = s_tdata[119:112];
	assign op             = op_t'(s_tuser);

	always_comb begin
		dir    = DIR_NONE;
		bucket = '0;
		if (op == OP_READ) begin
			bucket = read_bucket;
		end else if (dest_address == local_address_q) begin
			dir    = DIR_IN;
			bucket = form_bucket(source_address, source_port);
		end else if (source_address == local_address_q) begin
			dir    = DIR_OUT;
			bucket = form_bucket(dest_address, dest_port);
		end
	end

	assign s_tready         = !q_full && !clear_busy;
	assign push             = s_tvalid && s_tready;
	assign push_item.op     = op;
	assign push_item.dir    = dir;
	assign push_item.bucket = bucket;
	assign push_item.add    = {1'b0, wire_length} + {{(ADD_W-OVH_W){1'b0}}, length_overhead_q};

endmodule

`default_nettype wire

### hw/rtl/fbbc_queue.sv
// Short FIFO of classified items between the front end and the counter engine.
`default_nettype none

module fbbc_queue import fbbc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire work_t push_item,
	output logic       full,
	input  wire logic  pop,
	output logic       empty,
	output work_t      head
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	work_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

endmodule

`default_nettype wire

### hw/rtl/fbbc_back.sv
// Counter engine: table clear after reset, read-modify-write of bucket counters, result register.
`default_nettype none

module fbbc_back import fbbc_pkg::*; #(
	parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_empty,
	input  wire work_t                q_head,
	output logic                      q_pop,
	output logic                      clear_busy,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [DIR_W-1:0]          m_tuser,  // direction
	output logic [M_TDATA_W-1:0]      m_tdata   // bucket, inbound_bytes, outbound_bytes
);

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_ACCESS = 3'b100
	} state_t;

	state_t                     state_q;
	logic [BUCKET_W-1:0]        clr_idx_q;
	work_t                      item_s1;

	logic                       m_tvalid_q;
	logic [BUCKET_W-1:0]        m_bucket_q;
	dir_t                       m_dir_q;
	logic [OUT_CNT_W-1:0]       m_in_q;
	logic [OUT_CNT_W-1:0]       m_out_q;

	logic                       in_we;
	logic                       out_we;
	logic [BUCKET_W-1:0]        waddr;
	logic [COUNTER_WIDTH-1:0]   in_wdata;
	logic [COUNTER_WIDTH-1:0]   out_wdata;
	logic [COUNTER_WIDTH-1:0]   in_rdata;
	logic [COUNTER_WIDTH-1:0]   out_rdata;
	logic [COUNTER_WIDTH-1:0]   res_in;
	logic [COUNTER_WIDTH-1:0]   res_out;

	logic [COUNTER_WIDTH+ADD_W-1:0]     add_wide;
	logic [COUNTER_WIDTH-1:0]           add_ext;
	logic [COUNTER_WIDTH+OUT_CNT_W-1:0] res_in_wide;
	logic [COUNTER_WIDTH+OUT_CNT_W-1:0] res_out_wide;

	fbbc_ram #(
		.WIDTH (COUNTER_WIDTH),
		.DEPTH (BUCKET_COUNT)
	) u_inbound_ram (
		.clk   (clk),
		.we    (in_we),
		.waddr (waddr),
		.wdata (in_wdata),
		.raddr (q_head.bucket),
		.rdata (in_rdata)
	);

	fbbc_ram #(
		.WIDTH (COUNTER_WIDTH),
		.DEPTH (BUCKET_COUNT)
	) u_outbound_ram (
		.clk   (clk),
		.we    (out_we),
		.waddr (waddr),
		.wdata (out_wdata),
		.raddr (q_head.bucket),
		.rdata (out_rdata)
	);

	assign add_wide = {{COUNTER_WIDTH{1'b0}}, item_s1.add};
	assign add_ext  = add_wide[COUNTER_WIDTH-1:0];

	assign q_pop      = (state_q == ST_IDLE) && !q_empty && (!m_tvalid_q || m_tready);
	assign clear_busy = (state_q == ST_CLEAR);

	always_comb begin
		in_we     = 1'b0;
		out_we    = 1'b0;
		waddr     = item_s1.bucket;
		in_wdata  = '0;
		out_wdata = '0;
		res_in    = '0;
		res_out   = '0;
		case (state_q)
			ST_CLEAR: begin
				in_we  = 1'b1;
				out_we = 1'b1;
				waddr  = clr_idx_q;
			end
			ST_ACCESS: begin
				if (item_s1.op == OP_READ) begin
					in_we   = 1'b1;
					out_we  = 1'b1;
					res_in  = in_rdata;
					res_out = out_rdata;
				end else begin
					case (item_s1.dir)
						DIR_OUT: begin
							out_we    = 1'b1;
							out_wdata = out_rdata + add_ext;
							res_in    = in_rdata;
							res_out   = out_wdata;
						end
						DIR_IN: begin
							in_we    = 1'b1;
							in_wdata = in_rdata + add_ext;
							res_in   = in_wdata;
							res_out  = out_rdata;
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	assign res_in_wide  = {{OUT_CNT_W{1'b0}}, res_in};
	assign res_out_wide = {{OUT_CNT_W{1'b0}}, res_out};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_idx_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == BUCKET_W'(BUCKET_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_ACCESS;
					end
				end
				ST_ACCESS: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_ACCESS) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_head;
		end
		if (state_q == ST_ACCESS) begin
			m_bucket_q <= item_s1.bucket;
			m_dir_q    <= item_s1.dir;
			m_in_q     <= res_in_wide[OUT_CNT_W-1:0];
			m_out_q    <= res_out_wide[OUT_CNT_W-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_dir_q;
	assign m_tdata  = {m_out_q, m_in_q, m_bucket_q};

endmodule

`default_nettype wire

### hw/rtl/flow_bucket_byte_counter_core.sv
// Top level of the flow bucket byte counter: front end, item queue and counter engine.
//
// Counts bytes per traffic bucket for one monitored host. A count item (tuser 0) is classified
// against local_address as inbound (destination matches, wins over source) or outbound, hashed
// into one of 256 buckets from the remote address and port, and wire_length plus
// length_overhead is added to that bucket's counter; the result carries both counters after the
// update; one matching neither gives a zero result. A read item (tuser 1) returns a bucket's
// counters and clears them. Every item gives exactly one result. After reset the block zeroes
// both tables and holds s_tready low meanwhile. The counter engine starts the registered RAM
// read as it pops an item in idle, writes back in its access state and pops no new item until
// idle again; the front end keeps accepting into a two-entry queue while results wait at output.
`default_nettype none

module flow_bucket_byte_counter_core import fbbc_pkg::*; #(
	parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic                   s_tuser,   // op
	input  wire logic [S_TDATA_W-1:0]   s_tdata,   // source_address, dest_address, source_port,
	                                               // dest_port, wire_length, read_bucket
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [DIR_W-1:0]            m_tuser,   // direction
	output logic [M_TDATA_W-1:0]        m_tdata,   // bucket, inbound_bytes, outbound_bytes
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	logic  q_full;
	logic  q_empty;
	logic  q_push;
	logic  q_pop;
	logic  clear_busy;
	work_t push_item;
	work_t q_head;

	fbbc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.clear_busy (clear_busy),
		.push       (q_push),
		.push_item  (push_item)
	);

	fbbc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	fbbc_back #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.clear_busy (clear_busy),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tuser    (m_tuser),
		.m_tdata    (m_tdata)
	);

endmodule

`default_nettype wire

### hw/rtl/fbbc_checker.sv
// Port-level checker for the flow bucket byte counter, bound to the top level.
`default_nettype none

module fbbc_checker import fbbc_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [DIR_W-1:0]     m_tuser,
	input wire logic [M_TDATA_W-1:0] m_tdata
);

	localparam int unsigned MAX_PENDING = QUEUE_DEPTH + 2;

	logic [3:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == DIR_NONE) || (m_tuser == DIR_OUT) || (m_tuser == DIR_IN))
		else $error("illegal direction code");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != '0)
		else $error("result without an accepted item");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'(MAX_PENDING))
		else $error("more items in flight than the block can hold");

	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !s_tready)
		else $error("items accepted during table clear");

endmodule

bind flow_bucket_byte_counter_core fbbc_checker u_fbbc_checker (.*);

`default_nettype wire

### test/flow_bucket_byte_counter_core_tb.sv
// Self-checking testbench for the flow bucket byte counter: directed table, random traffic, single-bucket burst.
module flow_bucket_byte_counter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fbbc_pkg::*;

	localparam int unsigned MAX_GAP        = 8;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned WRAP_ITEMS     = 25;
	localparam int unsigned MAX_REPORTS    = 40;

	typedef struct packed {
		op_t         op;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] wire_len;
		logic [7:0]  rd_bucket;
	} packet_item_t;

	typedef struct packed {
		logic [7:0]  bucket;
		dir_t        dir;
		logic [31:0] in_bytes;
		logic [31:0] out_bytes;
	} flow_result_t;

	typedef struct {
		packet_item_t item;
		bit           typed;
		flow_result_t result;
	} directed_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic                   s_tuser = 1'b0;
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [DIR_W-1:0]       m_tuser;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic [31:0]     in_bytes_tab [BUCKET_COUNT];
	logic [31:0]     out_bytes_tab [BUCKET_COUNT];
	logic [31:0]     mon_local_addr;
	logic [7:0]      mon_overhead;
	flow_result_t    pending_results [$];
	directed_row_t   directed_table [$];
	int unsigned     mismatch_count = 0;
	int unsigned     stall_cycles = 0;
	bit              idle_off = 1'b0;
	bit              hold_req = 1'b0;

	flow_bucket_byte_counter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] remote_bucket(logic [31:0] addr, logic [15:0] port);
		if (addr == 32'd0) begin
			return 8'd0;
		end
		return {addr[31], addr[28], addr[24], addr[18], addr[13], port[15], port[10], port[4]};
	endfunction

	function automatic flow_result_t predict_flow(packet_item_t it);
		flow_result_t r;
		logic [31:0]  add;
		r = '0;
		add = {16'd0, it.wire_len} + {24'd0, mon_overhead};
		if (it.op == OP_READ) begin
			r.bucket = it.rd_bucket;
			r.in_bytes = in_bytes_tab[it.rd_bucket];
			r.out_bytes = out_bytes_tab[it.rd_bucket];
			in_bytes_tab[it.rd_bucket] = '0;
			out_bytes_tab[it.rd_bucket] = '0;
		end else begin
			if (it.dst_addr == mon_local_addr) begin
				r.dir = DIR_IN;
				r.bucket = remote_bucket(it.src_addr, it.src_port);
				in_bytes_tab[r.bucket] = in_bytes_tab[r.bucket] + add;
			end else if (it.src_addr == mon_local_addr) begin
				r.dir = DIR_OUT;
				r.bucket = remote_bucket(it.dst_addr, it.dst_port);
				out_bytes_tab[r.bucket] = out_bytes_tab[r.bucket] + add;
			end
			if (r.dir != DIR_NONE) begin
				r.in_bytes = in_bytes_tab[r.bucket];
				r.out_bytes = out_bytes_tab[r.bucket];
			end
		end
		return r;
	endfunction

	function automatic packet_item_t pkt(op_t op, logic [31:0] sa, logic [31:0] da,
			logic [15:0] sp, logic [15:0] dp, logic [15:0] len, logic [7:0] rb);
		packet_item_t it;
		it.op = op;
		it.src_addr = sa;
		it.dst_addr = da;
		it.src_port = sp;
		it.dst_port = dp;
		it.wire_len = len;
		it.rd_bucket = rb;
		return it;
	endfunction

	function automatic flow_result_t res(logic [7:0] b, dir_t d, logic [31:0] ib, logic [31:0] ob);
		flow_result_t r;
		r.bucket = b;
		r.dir = d;
		r.in_bytes = ib;
		r.out_bytes = ob;
		return r;
	endfunction

	function automatic directed_row_t row(packet_item_t it, bit typed, flow_result_t r);
		directed_row_t d;
		d.item = it;
		d.typed = typed;
		d.result = r;
		return d;
	endfunction

	function automatic packet_item_t random_item();
		packet_item_t it;
		int unsigned  kind;
		kind = $urandom_range(0, 99);
		it.op = OP_COUNT;
		it.src_addr = $urandom;
		it.dst_addr = $urandom;
		it.src_port = 16'($urandom);
		it.dst_port = 16'($urandom);
		it.wire_len = 16'($urandom);
		it.rd_bucket = 8'($urandom);
		if (kind < 10) begin
			it.op = OP_READ;
		end else if (kind < 50) begin
			it.src_addr = mon_local_addr;
			if ($urandom_range(0, 19) == 0) begin
				it.dst_addr = 32'd0;
			end
		end else if (kind < 85) begin
			it.dst_addr = mon_local_addr;
			if ($urandom_range(0, 19) == 0) begin
				it.src_addr = 32'd0;
			end
		end else if (kind < 90) begin
			it.src_addr = mon_local_addr;
			it.dst_addr = mon_local_addr;
		end else begin
			if (it.src_addr == mon_local_addr) begin
				it.src_addr = it.src_addr ^ 32'd1;
			end
			if (it.dst_addr == mon_local_addr) begin
				it.dst_addr = it.dst_addr ^ 32'd1;
			end
		end
		if ($urandom_range(0, 9) == 0) begin
			it.wire_len = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
		end
		return it;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
		end
	endtask

	task automatic send_item(packet_item_t it, bit typed, flow_result_t typed_result);
		int unsigned  gap;
		flow_result_t predicted;
		gap = idle_off ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.op;
		s_tdata <= {it.rd_bucket, it.wire_len, it.dst_port, it.src_port, it.dst_addr, it.src_addr};
		do @(posedge clk); while (!s_tready);
		predicted = predict_flow(it);
		pending_results.push_back(typed ? typed_result : predicted);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(logic [31:0] addr, logic [7:0] ovh);
		cfg_we <= 1'b1;
		cfg_index <= CFG_LOCAL_ADDRESS;
		cfg_data <= addr;
		@(posedge clk);
		cfg_index <= CFG_LENGTH_OVERHEAD;
		cfg_data <= {24'd0, ovh};
		@(posedge clk);
		cfg_we <= 1'b0;
		mon_local_addr = addr;
		mon_overhead = ovh;
	endtask

	task automatic run_random(int count, int quiet_until, int hold_at, int pause_at);
		for (int i = 0; i < count; i++) begin
			idle_off = (i < quiet_until);
			if (i == hold_at) begin
				hold_req = 1'b1;
			end
			if (i == pause_at) begin
				drain_results();
			end
			send_item(random_item(), 1'b0, '0);
		end
		idle_off = 1'b0;
		drain_results();
	endtask

	initial begin : receiver
		int unsigned gap;
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = idle_off ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && arst_n));
		end
	end

	always @(posedge clk) begin : result_check
		flow_result_t got;
		flow_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.bucket = m_tdata[7:0];
			got.dir = dir_t'(m_tuser);
			got.in_bytes = m_tdata[39:8];
			got.out_bytes = m_tdata[71:40];
			if (pending_results.size() == 0) begin
				report_mismatch("result with none pending", {24'd0, got.bucket}, 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (got.bucket !== want.bucket) begin
					report_mismatch("bucket", {24'd0, got.bucket}, {24'd0, want.bucket});
				end
				if (got.dir !== want.dir) begin
					report_mismatch("direction", {30'd0, got.dir}, {30'd0, want.dir});
				end
				if (got.in_bytes !== want.in_bytes) begin
					report_mismatch("inbound_bytes", got.in_bytes, want.in_bytes);
				end
				if (got.out_bytes !== want.out_bytes) begin
					report_mismatch("outbound_bytes", got.out_bytes, want.out_bytes);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < BUCKET_COUNT; k++) begin
			in_bytes_tab[k] = '0;
			out_bytes_tab[k] = '0;
		end
		mon_local_addr = LOCAL_ADDRESS_RESET;
		mon_overhead = LENGTH_OVERHEAD_RESET;

		directed_table.push_back(row(pkt(OP_READ, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'd0),
			1'b1, res(8'd0, DIR_NONE, 32'd0, 32'd0)));
		directed_table.push_back(row(pkt(OP_READ, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 8'd255), 1'b1, res(8'd255, DIR_NONE, 32'd0, 32'd0)));
		directed_table.push_back(row(pkt(OP_COUNT, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 8'd255), 1'b1, res(8'd0, DIR_NONE, 32'd0, 32'd0)));
		directed_table.push_back(row(pkt(OP_COUNT, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'd0),
			1'b1, res(8'd0, DIR_NONE, 32'd0, 32'd0)));
		directed_table.push_back(row(pkt(OP_COUNT, LOCAL_ADDRESS_RESET, 32'h0, 16'h0, 16'hFFFF,
			16'hFFFF, 8'd7), 1'b1, res(8'd0, DIR_OUT, 32'd0, 32'd65559)));
		directed_table.push_back(row(pkt(OP_COUNT, 32'h0, LOCAL_ADDRESS_RESET, 16'hFFFF, 16'h0,
			16'h0, 8'd0), 1'b1, res(8'd0, DIR_IN, 32'd24, 32'd65559)));
		directed_table.push_back(row(pkt(OP_READ, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'd0),
			1'b1, res(8'd0, DIR_NONE, 32'd24, 32'd65559)));
		directed_table.push_back(row(pkt(OP_READ, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'd0),
			1'b1, res(8'd0, DIR_NONE, 32'd0, 32'd0)));
		directed_table.push_back(row(pkt(OP_COUNT, LOCAL_ADDRESS_RESET, 32'hFFFFFFFF, 16'h0,
			16'hFFFF, 16'h0, 8'd0), 1'b1, res(8'd255, DIR_OUT, 32'd0, 32'd24)));
		directed_table.push_back(row(pkt(OP_COUNT, 32'hFFFFFFFF, LOCAL_ADDRESS_RESET, 16'hFFFF,
			16'h0, 16'hFFFF, 8'd0), 1'b1, res(8'd255, DIR_IN, 32'd65559, 32'd24)));
		directed_table.push_back(row(pkt(OP_READ, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'd255),
			1'b1, res(8'd255, DIR_NONE, 32'd65559, 32'd24)));
		directed_table.push_back(row(pkt(OP_COUNT, LOCAL_ADDRESS_RESET, LOCAL_ADDRESS_RESET,
			16'h8410, 16'h0, 16'd100, 8'd0), 1'b0, '0));
		directed_table.push_back(row(pkt(OP_COUNT, LOCAL_ADDRESS_RESET, 32'h80000000, 16'h0,
			16'h0, 16'd64, 8'd0), 1'b0, '0));
		directed_table.push_back(row(pkt(OP_COUNT, LOCAL_ADDRESS_RESET, 32'h10000000, 16'h0,
			16'h0, 16'd65, 8'd0), 1'b0, '0));
		directed_table.push_back(row(pkt(OP_COUNT, LOCAL_ADDRESS_RESET, 32'h01000000, 16'h0,
			16'h0, 16'd66, 8'd0), 1'b0, '0));
		directed_table.push_back(row(pkt(OP_COUNT, LOCAL_ADDRESS_RESET, 32'h00040000, 16'h0,
			16'h0, 16'd67, 8'd0), 1'b0, '0));
		directed_table.push_back(row(pkt(OP_COUNT, LOCAL_ADDRESS_RESET, 32'h00002000, 16'h0,
			16'h0, 16'd68, 8'd0), 1'b0, '0));
		directed_table.push_back(row(pkt(OP_COUNT, LOCAL_ADDRESS_RESET, 32'h00000001, 16'h0,
			16'h8000, 16'd69, 8'd0), 1'b0, '0));
		directed_table.push_back(row(pkt(OP_COUNT, LOCAL_ADDRESS_RESET, 32'h00000001, 16'h0,
			16'h0400, 16'd70, 8'd0), 1'b0, '0));
		directed_table.push_back(row(pkt(OP_COUNT, LOCAL_ADDRESS_RESET, 32'h00000001, 16'h0,
			16'h0010, 16'd71, 8'd0), 1'b0, '0));
		directed_table.push_back(row(pkt(OP_COUNT, LOCAL_ADDRESS_RESET, 32'h6EFBDFFF, 16'h0,
			16'h7BEF, 16'd72, 8'd0), 1'b0, '0));
		directed_table.push_back(row(pkt(OP_COUNT, 32'h12345678, LOCAL_ADDRESS_RESET, 16'h1234,
			16'hABCD, 16'd1500, 8'd0), 1'b0, '0));
		directed_table.push_back(row(pkt(OP_READ, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'h80),
			1'b0, '0));
		directed_table.push_back(row(pkt(OP_READ, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'd0),
			1'b0, '0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		write_config(LOCAL_ADDRESS_RESET, LENGTH_OVERHEAD_RESET);
		foreach (directed_table[i]) begin
			send_item(directed_table[i].item, directed_table[i].typed, directed_table[i].result);
		end
		drain_results();

		run_random(400, 100, -1, -1);
		write_config(32'h00000000, 8'd0);
		run_random(350, 0, 150, -1);
		write_config(32'hFFFFFFFF, 8'd255);
		run_random(350, 0, -1, 175);
		write_config($urandom, 8'($urandom));
		run_random(350, 0, -1, -1);
		write_config($urandom, 8'd1);
		run_random(350, 0, -1, -1);

		write_config(LOCAL_ADDRESS_RESET, 8'd255);
		idle_off = 1'b1;
		for (int i = 0; i < WRAP_ITEMS; i++) begin
			send_item(pkt(OP_COUNT, LOCAL_ADDRESS_RESET, 32'hFFFFFFFF, 16'($urandom), 16'hFFFF,
				16'hFFFF, 8'($urandom)), 1'b0, '0);
		end
		send_item(pkt(OP_READ, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'd255), 1'b0, '0);
		idle_off = 1'b0;
		drain_results();

		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
